/* src/pftp_pkg.sv */
package pftp_pkg;

  localparam int COORD_BITS_DEF       = 24;
  localparam int NORMAL_FRAC_BITS_DEF = 30;
  localparam int NORMAL_W             = 32;
  localparam int LIMIT_W              = 64;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 64'd18446744;
  // limb width of the split multipliers
  localparam int SQ_LIMB              = 26;

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

/* src/pftp_if.sv */
interface pftp_in_if import pftp_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_a_x;
  logic signed [COORD_BITS-1:0] point_a_y;
  logic signed [COORD_BITS-1:0] point_a_z;
  logic signed [COORD_BITS-1:0] point_b_x;
  logic signed [COORD_BITS-1:0] point_b_y;
  logic signed [COORD_BITS-1:0] point_b_z;
  logic signed [COORD_BITS-1:0] point_c_x;
  logic signed [COORD_BITS-1:0] point_c_y;
  logic signed [COORD_BITS-1:0] point_c_z;

  modport source (
    output valid, point_a_x, point_a_y, point_a_z, point_b_x, point_b_y, point_b_z,
           point_c_x, point_c_y, point_c_z,
    input  ready
  );
  modport sink (
    input  valid, point_a_x, point_a_y, point_a_z, point_b_x, point_b_y, point_b_z,
           point_c_x, point_c_y, point_c_z,
    output ready
  );
endinterface

interface pftp_out_if import pftp_pkg::*; #(
  parameter int OFFSET_BITS = COORD_BITS_DEF + 1
);
  logic                          valid;
  logic                          ready;
  logic signed [NORMAL_W-1:0]    normal_x;
  logic signed [NORMAL_W-1:0]    normal_y;
  logic signed [NORMAL_W-1:0]    normal_z;
  logic signed [OFFSET_BITS-1:0] plane_offset;
  logic                          plane_valid;

  modport source (
    output valid, normal_x, normal_y, normal_z, plane_offset, plane_valid,
    input  ready
  );
  modport sink (
    input  valid, normal_x, normal_y, normal_z, plane_offset, plane_valid,
    output ready
  );
endinterface

/* src/pftp_sqr.sv */
// Pipelined squarer: limb products, row sums, final sum (three stages).
module pftp_sqr import pftp_pkg::*; #(
  parameter int W     = 51,
  parameter int LANES = 1,
  parameter int SW    = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [LANES-1:0][W-1:0]     x,
  input  logic [SW-1:0]               side_in,
  output logic                        out_valid,
  output logic [LANES-1:0][2*W-1:0]   y,
  output logic [SW-1:0]               side_out
);

  localparam int L  = SQ_LIMB;
  localparam int N  = (W + L - 1) / L;
  localparam int NL = N * L;

  logic [LANES-1:0][NL-1:0]          xp;
  logic [2*L-1:0]                    pp       [LANES][N*N];
  logic [2*NL-1:0]                   row_next [LANES][N];
  logic [2*NL-1:0]                   rowsum   [LANES][N];
  logic [LANES-1:0][2*NL-1:0]        total_next;
  logic [LANES-1:0][2*NL-1:0]        total;
  logic [2:0]                        vld;
  logic [SW-1:0]                     side1, side2, side3;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      xp[l] = NL'(x[l]);
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      for (int i = 0; i < N; i++) begin
        row_next[l][i] = '0;
        for (int j = 0; j < N; j++) begin
          row_next[l][i] = row_next[l][i] + ((2*NL)'(pp[l][i*N+j]) << (j*L));
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      total_next[l] = '0;
      for (int i = 0; i < N; i++) begin
        total_next[l] = total_next[l] + (rowsum[l][i] << (i*L));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        for (int i = 0; i < N; i++) begin
          for (int j = 0; j < N; j++) begin
            pp[l][i*N+j] <= xp[l][i*L +: L] * xp[l][j*L +: L];
          end
          rowsum[l][i] <= row_next[l][i];
        end
      end
      total <= total_next;
      side1 <= side_in;
      side2 <= side1;
      side3 <= side2;
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      y[l] = total[l][2*W-1:0];
    end
  end

  assign out_valid = vld[2];
  assign side_out  = side3;

endmodule

/* src/pftp_div.sv */
// Restoring divider, one quotient bit per stage, divisor shared by the lanes.
// The top QW bits of the quotient must cover it: dividend >> QW < divisor.
module pftp_div import pftp_pkg::*; #(
  parameter int DVW   = 162,
  parameter int DW    = 104,
  parameter int QW    = 61,
  parameter int LANES = 1,
  parameter int SW    = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [LANES-1:0][DVW-1:0]   dividend,
  input  logic [DW-1:0]               divisor,
  input  logic [SW-1:0]               side_in,
  output logic                        out_valid,
  output logic [LANES-1:0][QW-1:0]    quotient,
  output logic [SW-1:0]               side_out
);

  logic [LANES-1:0][DW-1:0] rem [QW+1];
  logic [LANES-1:0][QW-1:0] low [QW+1];
  logic [LANES-1:0][QW-1:0] quo [QW+1];
  logic [DW-1:0]            dvs [QW+1];
  logic [SW-1:0]            sd  [QW+1];
  logic                     vld [QW+1];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rem[0][l] = DW'(dividend[l] >> QW);
      low[0][l] = dividend[l][QW-1:0];
      quo[0][l] = '0;
    end
  end
  assign dvs[0] = divisor;
  assign sd[0]  = side_in;
  assign vld[0] = in_valid;

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [LANES-1:0][DW:0]   t;
    logic [LANES-1:0][DW:0]   diff;
    logic [LANES-1:0]         ge;
    logic [LANES-1:0][DW-1:0] rem_next;
    logic [LANES-1:0][QW-1:0] quo_next;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        t[l]        = {rem[k][l], low[k][l][QW-1]};
        diff[l]     = t[l] - {1'b0, dvs[k]};
        ge[l]       = t[l] >= {1'b0, dvs[k]};
        rem_next[l] = ge[l] ? diff[l][DW-1:0] : t[l][DW-1:0];
        quo_next[l] = {quo[k][l][QW-2:0], ge[l]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= rem_next;
        quo[k+1] <= quo_next;
        for (int l = 0; l < LANES; l++) begin
          low[k+1][l] <= low[k][l] << 1;
        end
        dvs[k+1] <= dvs[k];
        sd[k+1]  <= sd[k];
      end
    end
  end

  assign out_valid = vld[QW];
  assign quotient  = quo[QW];
  assign side_out  = sd[QW];

endmodule

/* src/pftp_sqrt.sv */
// Integer square root, floor, two radicand bits per stage.
module pftp_sqrt import pftp_pkg::*; #(
  parameter int XW    = 61,
  parameter int LANES = 1,
  parameter int SW    = 1,
  localparam int RW   = (XW + 1) / 2
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [LANES-1:0][XW-1:0]    x,
  input  logic [SW-1:0]               side_in,
  output logic                        out_valid,
  output logic [LANES-1:0][RW-1:0]    root,
  output logic [SW-1:0]               side_out
);

  localparam int XP = 2 * RW;

  logic [LANES-1:0][RW+1:0] rem [RW+1];
  logic [LANES-1:0][RW-1:0] rt  [RW+1];
  logic [LANES-1:0][XP-1:0] low [RW+1];
  logic [SW-1:0]            sd  [RW+1];
  logic                     vld [RW+1];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rem[0][l] = '0;
      rt[0][l]  = '0;
      low[0][l] = XP'(x[l]);
    end
  end
  assign sd[0]  = side_in;
  assign vld[0] = in_valid;

  for (genvar k = 0; k < RW; k++) begin : g_step
    logic [LANES-1:0][RW+3:0] t;
    logic [LANES-1:0][RW+3:0] trial;
    logic [LANES-1:0][RW+3:0] diff;
    logic [LANES-1:0]         ge;
    logic [LANES-1:0][RW+1:0] rem_next;
    logic [LANES-1:0][RW-1:0] rt_next;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        t[l]        = {rem[k][l], low[k][l][XP-1:XP-2]};
        trial[l]    = (RW+4)'({rt[k][l], 2'b01});
        diff[l]     = t[l] - trial[l];
        ge[l]       = t[l] >= trial[l];
        rem_next[l] = ge[l] ? diff[l][RW+1:0] : t[l][RW+1:0];
        rt_next[l]  = {rt[k][l][RW-2:0], ge[l]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= rem_next;
        rt[k+1]  <= rt_next;
        for (int l = 0; l < LANES; l++) begin
          low[k+1][l] <= low[k][l] << 2;
        end
        sd[k+1] <= sd[k];
      end
    end
  end

  assign out_valid = vld[RW];
  assign root      = rt[RW];
  assign side_out  = sd[RW];

endmodule

/* src/plane_from_three_points_top.sv */
// Plane through three points: exact cross product, unit normal and offset.
// Pipeline of register stages; the bit-per-stage divider has QW of them and the root
// ceil(QW/2), with QW = max(2*NF+1, 2*CW+2).
// Throughput one request per cycle; the whole pipe holds only while a result waits.
// Reset clears every valid bit and loads the degeneracy limit with its default.
module plane_from_three_points_top import pftp_pkg::*; #(
  parameter int COORD_BITS       = COORD_BITS_DEF,
  parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  pftp_in_if.sink             points,
  pftp_out_if.source          plane,
  input  logic                cfg_write,
  input  logic [LIMIT_W-1:0]  cfg_data
);

  localparam int CW   = COORD_BITS;
  localparam int NF   = NORMAL_FRAC_BITS;
  localparam int UW   = CW + 1;
  localparam int PRW  = 2 * UW;
  localparam int CRW  = PRW + 1;
  localparam int C2W  = 2 * CRW;
  localparam int SUMW = C2W + 2;
  localparam int CMPW = imax(SUMW, LIMIT_W);
  localparam int H    = CRW / 2;
  localparam int HW   = CRW - H;
  localparam int PW   = CRW + CW + 2;
  localparam int P2W  = 2 * PW;
  localparam int QW   = imax(2 * NF + 1, 2 * CW + 2);
  localparam int DVW  = imax(C2W + 2 * NF, P2W + 2);
  localparam int RW   = (QW + 1) / 2;
  localparam int OW   = CW + 1;
  localparam int SDW  = SUMW + 3 * C2W + 4;

  logic [LIMIT_W-1:0] limit;
  logic               en;
  logic               out_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_write) begin
      limit <= cfg_data;
    end
  end

  assign en           = !out_vld || plane.ready;
  assign points.ready = en;

  logic signed [CW-1:0] pa [3];
  logic signed [CW-1:0] pb [3];
  logic signed [CW-1:0] pc [3];
  assign pa[0] = points.point_a_x;
  assign pa[1] = points.point_a_y;
  assign pa[2] = points.point_a_z;
  assign pb[0] = points.point_b_x;
  assign pb[1] = points.point_b_y;
  assign pb[2] = points.point_b_z;
  assign pc[0] = points.point_c_x;
  assign pc[1] = points.point_c_y;
  assign pc[2] = points.point_c_z;

  // stages 1-3: edge vectors, cross partial products, cross product
  logic                  v1, v2, v3;
  logic signed [UW-1:0]  u1 [3];
  logic signed [UW-1:0]  w1 [3];
  logic signed [CW-1:0]  a1 [3];
  logic signed [CW-1:0]  a2 [3];
  logic signed [CW-1:0]  a3 [3];
  logic signed [PRW-1:0] pl2 [3];
  logic signed [PRW-1:0] pr2 [3];
  logic signed [CRW-1:0] cr3 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= points.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        u1[i]  <= UW'(pb[i]) - UW'(pa[i]);
        w1[i]  <= UW'(pc[i]) - UW'(pa[i]);
        a1[i]  <= pa[i];
        a2[i]  <= a1[i];
        a3[i]  <= a2[i];
        cr3[i] <= CRW'(pl2[i]) - CRW'(pr2[i]);
      end
      pl2[0] <= u1[1] * w1[2];
      pr2[0] <= u1[2] * w1[1];
      pl2[1] <= u1[2] * w1[0];
      pr2[1] <= u1[0] * w1[2];
      pl2[2] <= u1[0] * w1[1];
      pr2[2] <= u1[1] * w1[0];
    end
  end

  // stages 4-6: squares of the cross components, dot product with point a
  logic [2:0][CRW-1:0]     cmag;
  logic [2:0]              csgn3;
  logic [2:0][C2W-1:0]     c2;
  logic [2:0]              csgn6;
  logic                    v6;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cmag[i]  = cr3[i][CRW-1] ? -cr3[i] : cr3[i];
      csgn3[i] = cr3[i][CRW-1];
    end
  end

  pftp_sqr #(.W(CRW), .LANES(3), .SW(3)) u_sqr_c (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v3), .x(cmag), .side_in(csgn3),
    .out_valid(v6), .y(c2), .side_out(csgn6)
  );

  logic signed [H+CW:0]     plo4 [3];
  logic signed [HW+CW-1:0]  phi4 [3];
  logic signed [PW-1:0]     pc5  [3];
  logic signed [PW-1:0]     p6;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        plo4[i] <= $signed({1'b0, cr3[i][H-1:0]}) * a3[i];
        phi4[i] <= $signed(cr3[i][CRW-1:H]) * a3[i];
        pc5[i]  <= (PW'(phi4[i]) <<< H) + PW'(plo4[i]);
      end
      p6 <= pc5[0] + pc5[1] + pc5[2];
    end
  end

  // stage 7: squared norm, magnitude of the dot product
  logic                 v7;
  logic [SUMW-1:0]      s7;
  logic [2:0][C2W-1:0]  c2_7;
  logic [2:0]           csgn7;
  logic                 pneg7;
  logic [0:0][PW-1:0]   pmag7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7       <= SUMW'(c2[0]) + SUMW'(c2[1]) + SUMW'(c2[2]);
      c2_7     <= c2;
      csgn7    <= csgn6;
      pneg7    <= p6[PW-1];
      pmag7[0] <= p6[PW-1] ? -p6 : p6;
    end
  end

  // stages 8-10: square of the dot product
  logic                v10;
  logic [0:0][P2W-1:0] p2;
  logic [SDW-1:0]      sd10;
  logic [SUMW-1:0]     s10;
  logic [2:0][C2W-1:0] c2_10;
  logic [2:0]          csgn10;
  logic                pneg10;

  pftp_sqr #(.W(PW), .LANES(1), .SW(SDW)) u_sqr_p (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v7), .x(pmag7), .side_in({s7, c2_7, csgn7, pneg7}),
    .out_valid(v10), .y(p2), .side_out(sd10)
  );

  assign {s10, c2_10, csgn10, pneg10} = sd10;

  // stage 11: dividends and degeneracy test
  logic                v11;
  logic [3:0][DVW-1:0] dv11;
  logic [SUMW-1:0]     s11;
  logic [4:0]          flags11;

  always_ff @(posedge clk) begin
    if (rst) begin
      v11 <= 1'b0;
    end else if (en) begin
      v11 <= v10;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dv11[i] <= DVW'(c2_10[i]) << (2 * NF);
      end
      dv11[3] <= DVW'(p2[0]) << 2;
      s11     <= s10;
      flags11 <= {(s10 == '0) || (CMPW'(s10) < CMPW'(limit)), csgn10, pneg10};
    end
  end

  // per lane: floor(c^2 * 2^2NF / S) and floor(4 p^2 / S), then their roots
  logic                v_div;
  logic [3:0][QW-1:0]  quo;
  logic [4:0]          flags_div;
  logic                v_rt;
  logic [3:0][RW-1:0]  rt;
  logic [4:0]          flags_rt;

  pftp_div #(.DVW(DVW), .DW(SUMW), .QW(QW), .LANES(4), .SW(5)) u_div (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v11), .dividend(dv11), .divisor(s11), .side_in(flags11),
    .out_valid(v_div), .quotient(quo), .side_out(flags_div)
  );

  pftp_sqrt #(.XW(QW), .LANES(4), .SW(5)) u_sqrt (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v_div), .x(quo), .side_in(flags_div),
    .out_valid(v_rt), .root(rt), .side_out(flags_rt)
  );

  // output stage: signs, rounding of the offset, degenerate masking
  logic                        degen;
  logic signed [NORMAL_W-1:0]  nrm_next [3];
  logic signed [NORMAL_W-1:0]  nrm      [3];
  logic [RW:0]                 half_up;
  logic signed [OW-1:0]        omag;
  logic signed [OW-1:0]        off_next;
  logic signed [OW-1:0]        off;
  logic                        pv;

  assign degen   = flags_rt[4];
  // root of 4p^2/S is floor(2y); (k + 1) / 2 rounds y half away from zero
  assign half_up = ((RW+1)'(rt[3]) + (RW+1)'(1)) >> 1;
  assign omag    = OW'(half_up);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (degen) begin
        nrm_next[i] = '0;
      end else if (flags_rt[i+1]) begin
        nrm_next[i] = -NORMAL_W'(rt[i][NF:0]);
      end else begin
        nrm_next[i] = NORMAL_W'(rt[i][NF:0]);
      end
    end
    if (degen) begin
      off_next = '0;
    end else if (!flags_rt[0]) begin
      off_next = -omag;
    end else begin
      off_next = omag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= v_rt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nrm <= nrm_next;
      off <= off_next;
      pv  <= !degen;
    end
  end

  assign plane.valid        = out_vld;
  assign plane.normal_x     = nrm[0];
  assign plane.normal_y     = nrm[1];
  assign plane.normal_z     = nrm[2];
  assign plane.plane_offset = off;
  assign plane.plane_valid  = pv;

endmodule

/* src/pftp_checker.sv */
module pftp_checker import pftp_pkg::*; #(
  parameter int OFFSET_W         = COORD_BITS_DEF + 1,
  parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [NORMAL_W-1:0] normal_x,
  input logic signed [NORMAL_W-1:0] normal_y,
  input logic signed [NORMAL_W-1:0] normal_z,
  input logic signed [OFFSET_W-1:0] plane_offset,
  input logic                       plane_valid
);

  localparam logic signed [NORMAL_W-1:0] UNIT = NORMAL_W'(1) <<< NORMAL_FRAC_BITS;

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(normal_x) && $stable(normal_y)
      && $stable(normal_z) && $stable(plane_offset) && $stable(plane_valid))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result presented straight after reset");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !plane_valid |-> normal_x == '0 && normal_y == '0 && normal_z == '0
      && plane_offset == '0)
    else $error("degenerate result carries nonzero fields");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && plane_valid |-> normal_x <= UNIT && normal_x >= -UNIT
      && normal_y <= UNIT && normal_y >= -UNIT && normal_z <= UNIT && normal_z >= -UNIT)
    else $error("normal component beyond unit magnitude");

  a_free_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("request refused with empty output");

endmodule

bind plane_from_three_points_top pftp_checker #(
  .OFFSET_W(COORD_BITS + 1),
  .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)
) u_pftp_checker (
  .clk(clk),
  .rst(rst),
  .in_ready(points.ready),
  .out_valid(plane.valid),
  .out_ready(plane.ready),
  .normal_x(plane.normal_x),
  .normal_y(plane.normal_y),
  .normal_z(plane.normal_z),
  .plane_offset(plane.plane_offset),
  .plane_valid(plane.plane_valid)
);

/* tb/tb_pftp_if.sv */
`timescale 1ns / 1ps

// Plain instances of the block's channels are made in tb_top; this file holds the
// package tb_pftp_types with the bench's record types for a point triple and a
// plane result.
package tb_pftp_types;
  import pftp_pkg::*;

  typedef struct {
    logic signed [COORD_BITS_DEF-1:0] crd [9];
  } point_triple_t;

  typedef struct {
    logic signed [NORMAL_W-1:0]         nrm [3];
    logic signed [COORD_BITS_DEF:0]     offset;
    logic                               ok;
  } plane_t;
endpackage

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import pftp_pkg::*;
  import tb_pftp_types::*;

  localparam int CW = COORD_BITS_DEF;
  localparam int DRAIN = 120;
  localparam int STUCK_LIMIT = 3000;
  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [LIMIT_W-1:0] cfg_data = '0;

  pftp_in_if  #(.COORD_BITS(CW))    points ();
  pftp_out_if #(.OFFSET_BITS(CW+1)) plane ();

  plane_from_three_points_top u_top (
    .clk(clk), .rst(rst), .points(points.sink), .plane(plane.source),
    .cfg_write(cfg_write), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  class plane_board;
    logic [LIMIT_W-1:0] limit;
    plane_t pending [$];
    int errors;

    function new();
      limit = LIMIT_RESET;
      errors = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function automatic plane_t predict(point_triple_t t);
      logic signed [255:0] p [9];
      logic signed [255:0] u [3];
      logic signed [255:0] v [3];
      logic signed [255:0] cr [3];
      logic signed [255:0] dotp;
      logic [255:0] s, m, target, cand, acc, odd;
      plane_t r;
      for (int i = 0; i < 9; i++) p[i] = t.crd[i];
      for (int i = 0; i < 3; i++) begin
        u[i] = p[3+i] - p[i];
        v[i] = p[6+i] - p[i];
      end
      cr[0] = u[1]*v[2] - u[2]*v[1];
      cr[1] = u[2]*v[0] - u[0]*v[2];
      cr[2] = u[0]*v[1] - u[1]*v[0];
      s = cr[0]*cr[0] + cr[1]*cr[1] + cr[2]*cr[2];
      r.nrm[0] = '0; r.nrm[1] = '0; r.nrm[2] = '0; r.offset = '0; r.ok = 1'b0;
      if (s == 0 || s < {192'd0, limit}) return r;
      for (int i = 0; i < 3; i++) begin
        m = cr[i][255] ? -cr[i] : cr[i];
        target = (m*m) << (2*NORMAL_FRAC_BITS_DEF);
        acc = '0;
        for (int b = NORMAL_FRAC_BITS_DEF; b >= 0; b--) begin
          cand = acc | (256'd1 << b);
          if (cand*cand*s <= target) acc = cand;
        end
        r.nrm[i] = cr[i][255] ? -acc[NORMAL_W-1:0] : acc[NORMAL_W-1:0];
      end
      dotp = cr[0]*p[0] + cr[1]*p[1] + cr[2]*p[2];
      m = dotp[255] ? -dotp : dotp;
      target = (m*m) << 2;
      acc = '0;
      // rounding: largest r with (2r-1)^2 * s <= 4 m^2
      for (int b = CW; b >= 0; b--) begin
        cand = acc | (256'd1 << b);
        odd = 2*cand - 1;
        if (odd*odd*s <= target) acc = cand;
      end
      r.offset = (dotp > 0) ? -acc[CW:0] : acc[CW:0];
      r.ok = 1'b1;
      return r;
    endfunction

    function void note(point_triple_t t);
      pending.insert(pending.size(), predict(t));
    endfunction

    task check(plane_t got);
      plane_t want;
      if (pending.size() == 0) begin
        report("result with no request outstanding");
        return;
      end
      want = pending.pop_front();
      for (int i = 0; i < 3; i++)
        if (got.nrm[i] !== want.nrm[i])
          report($sformatf("normal[%0d] got %0d want %0d", i, got.nrm[i], want.nrm[i]));
      if (got.offset !== want.offset)
        report($sformatf("plane_offset got %0d want %0d", got.offset, want.offset));
      if (got.ok !== want.ok)
        report($sformatf("plane_valid got %0b want %0b", got.ok, want.ok));
    endtask
  endclass

  plane_board board = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int stuck = 0;

  always @(posedge clk) begin
    plane.ready <= !rst && ($urandom_range(99) >= stall_pct);
  end

  // monitor: note accepted requests, check results, watch for a hang
  always @(posedge clk) begin
    point_triple_t t;
    plane_t got;
    if (!rst) begin
      if (points.valid && points.ready) begin
        t.crd[0] = points.point_a_x; t.crd[1] = points.point_a_y;
        t.crd[2] = points.point_a_z; t.crd[3] = points.point_b_x;
        t.crd[4] = points.point_b_y; t.crd[5] = points.point_b_z;
        t.crd[6] = points.point_c_x; t.crd[7] = points.point_c_y;
        t.crd[8] = points.point_c_z;
        board.note(t);
      end
      if (plane.valid && plane.ready) begin
        got.nrm[0] = plane.normal_x; got.nrm[1] = plane.normal_y;
        got.nrm[2] = plane.normal_z; got.offset = plane.plane_offset;
        got.ok = plane.plane_valid;
        board.check(got);
      end
      if ((points.valid && points.ready) || (plane.valid && plane.ready)) stuck = 0;
      else stuck++;
      if (stuck >= STUCK_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  task push(point_triple_t t);
    while ($urandom_range(99) < idle_pct) begin
      points.valid <= 1'b0;
      @(posedge clk);
    end
    points.valid <= 1'b1;
    points.point_a_x <= t.crd[0]; points.point_a_y <= t.crd[1];
    points.point_a_z <= t.crd[2]; points.point_b_x <= t.crd[3];
    points.point_b_y <= t.crd[4]; points.point_b_z <= t.crd[5];
    points.point_c_x <= t.crd[6]; points.point_c_y <= t.crd[7];
    points.point_c_z <= t.crd[8];
    @(posedge clk);
    while (!points.ready) @(posedge clk);
  endtask

  task drain();
    points.valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task set_limit(logic [LIMIT_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    board.limit = val;
    @(posedge clk);
  endtask

  function automatic point_triple_t mk(int ax, int ay, int az, int bx, int by, int bz,
                                       int cx, int cy, int cz);
    point_triple_t t;
    t.crd[0] = CW'(ax); t.crd[1] = CW'(ay); t.crd[2] = CW'(az);
    t.crd[3] = CW'(bx); t.crd[4] = CW'(by); t.crd[5] = CW'(bz);
    t.crd[6] = CW'(cx); t.crd[7] = CW'(cy); t.crd[8] = CW'(cz);
    return t;
  endfunction

  function automatic int rnd_coord(int bits);
    int span;
    span = (1 << (bits - 1)) - 1;
    return $urandom_range(2*span) - span;
  endfunction

  function automatic point_triple_t rnd_triple();
    point_triple_t t;
    int kind, w, k;
    int d [3];
    kind = $urandom_range(9);
    if (kind < 4) begin
      for (int i = 0; i < 9; i++) t.crd[i] = CW'($urandom);
    end else if (kind < 7) begin
      // small spread around a random anchor: S near the limit
      w = $urandom_range(12, 2);
      for (int i = 0; i < 3; i++) t.crd[i] = CW'(rnd_coord(22));
      for (int i = 3; i < 9; i++) t.crd[i] = CW'(t.crd[i%3] + rnd_coord(w));
    end else if (kind < 9) begin
      // collinear: c = a + k*(b - a)
      k = $urandom_range(6) - 3;
      for (int i = 0; i < 3; i++) begin
        t.crd[i] = CW'(rnd_coord(21));
        d[i] = rnd_coord(18);
        t.crd[3+i] = CW'(t.crd[i] + d[i]);
        t.crd[6+i] = CW'(t.crd[i] + k*d[i]);
      end
    end else begin
      for (int i = 0; i < 3; i++) t.crd[i] = CW'($urandom);
      for (int i = 3; i < 9; i++)
        t.crd[i] = ($urandom_range(1) != 0) ? t.crd[i%3] : CW'($urandom);
    end
    return t;
  endfunction

  task run_random(int n);
    for (int i = 0; i < n; i++) begin
      push(rnd_triple());
      if (i == n/2 && $urandom_range(1)) drain();
    end
  endtask

  initial begin
    points.valid = 1'b0;
    points.point_a_x = '0; points.point_a_y = '0; points.point_a_z = '0;
    points.point_b_x = '0; points.point_b_y = '0; points.point_b_z = '0;
    points.point_c_x = '0; points.point_c_y = '0; points.point_c_z = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset limit, no idling
    push(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
    push(mk(0, 0, 0, 1, 0, 0, 0, 1, 0));
    push(mk(0, 0, 0, 65536, 0, 0, 0, 65536, 0));
    push(mk(CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN));
    push(mk(CMAX, CMAX, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX));
    push(mk(CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN));
    push(mk(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
    push(mk(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0, 0, 0));
    push(mk(1, 2, 3, 3, 6, 9, 5, 10, 15));
    push(mk(CMAX, 0, 0, 0, CMAX, 0, 0, 0, CMAX));
    push(mk(CMIN, 0, 0, 0, CMIN, 0, 0, 0, CMIN));
    push(mk(CMAX, CMAX, CMAX, CMAX - 1, CMAX, CMAX, CMAX, CMAX - 1, CMAX));
    push(mk(100, -200, 300, 100, -200, 300, -7, 9, 11));
    push(mk(-1, -1, -1, 1, -1, -1, -1, 1, -1));
    push(mk(123456, -654321, 777, -98765, 4321, -1, 55555, 66666, -77777));
    run_random(450);
    drain();

    // limit zero: only triples with S = 0 (collinear or coincident) degenerate
    set_limit('0);
    idle_pct = 82;
    push(mk(0, 0, 0, 1, 0, 0, 0, 1, 0));
    push(mk(5, 5, 5, 5, 5, 5, 5, 5, 5));
    push(mk(1, 2, 3, 3, 6, 9, 5, 10, 15));
    run_random(450);
    drain();

    // S = 1 sits exactly on a limit of 1
    set_limit(64'd1);
    idle_pct = 0;
    stall_pct = 82;
    push(mk(0, 0, 0, 1, 0, 0, 0, 1, 0));
    drain();
    set_limit(64'd2);
    push(mk(0, 0, 0, 1, 0, 0, 0, 1, 0));
    drain();

    set_limit({LIMIT_W{1'b1}});
    run_random(450);
    drain();

    set_limit(64'h0000_0100_0000_0000);
    idle_pct = 17;
    stall_pct = 17;
    run_random(450);
    drain();

    if (board.errors == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule

/* files.f */
src/pftp_pkg.sv
src/pftp_if.sv
src/pftp_sqr.sv
src/pftp_div.sv
src/pftp_sqrt.sv
src/plane_from_three_points_top.sv
src/pftp_checker.sv
tb/tb_pftp_if.sv
tb/tb_top.sv
